>>> hdl/efm_pkg.sv
// efm_pkg: shared types and constants for the edge frequency meter
// holds the request and response beat structs and the controller/datapath interface
// no dependencies
package efm_pkg;

    localparam int RATE_W      = 32;
    localparam int CYC_W       = 32;
    localparam int FREQ_W      = 32;
    localparam int EMA_SHIFT   = 3;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(200000000);

    typedef enum logic [1:0] {
        REQ_EDGE  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_BASE  = 2'd2
    } req_code_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [CYC_W-1:0] now_cycles;
    } efm_req_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_hz;
        logic              signal_absent;
    } efm_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic edge_inc;
        logic base_set;
        logic query_start;
        logic mul_step;
        logic div_step;
        logic div_high;
        logic finish;
    } efm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic absent;
        logic out_free;
    } efm_sts_t;

endpackage

>>> hdl/efm_ctrl.sv
// efm_ctrl: sequencer for the edge frequency meter
// decodes request beats and steps the multiply and divide phases; uses efm_pkg
module efm_ctrl import efm_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic [1:0] req_type,
    output logic     req_stall,
    input  efm_sts_t sts,
    output efm_cmd_t cmd
);

    localparam int PW     = COUNT_WIDTH + RATE_W;
    localparam int STEP_W = $clog2(PW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              accept;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_EDGE:  cmd.edge_inc = 1'b1;
                        REQ_BASE:  cmd.base_set = 1'b1;
                        REQ_QUERY:
                        begin
                            cmd.query_start = 1'b1;
                            state_next      = ST_MUL;
                            cnt_next        = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL:
            begin
                if (sts.absent)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_reg == STEP_W'(RATE_W - 1))
                    begin
                        state_next = ST_DIV;
                        cnt_next   = STEP_W'(PW - 1);
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                // quotient bits above the result width only flag saturation
                cmd.div_high = (cnt_reg >= STEP_W'(FREQ_W));
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_finish_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result written while output slot occupied");

    a_steps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mul_step && cmd.div_step))
        else $error("multiply and divide step in the same cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.query_start |=> req_stall)
        else $error("query start did not hold off new beats");

    a_div_high_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_high |-> cmd.div_step)
        else $error("saturation flag outside a divide step");

endmodule

>>> hdl/efm_dp.sv
// efm_dp: datapath of the edge frequency meter
// counters, shift-add multiplier, restoring divider, smoothing and output register; uses efm_pkg
module efm_dp import efm_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  efm_cmd_t          cmd,
    output efm_sts_t          sts,
    input  logic [CYC_W-1:0]  now_cycles,
    input  logic              cfg_we,
    input  logic [RATE_W-1:0] cfg_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output efm_rsp_t          rsp
);

    localparam int PW = COUNT_WIDTH + RATE_W;

    logic [COUNT_WIDTH-1:0] edge_total_reg, last_edges_reg;
    logic [CYC_W-1:0]       last_cycles_reg;
    logic [FREQ_W-1:0]      avg_reg, avg_next;
    logic [RATE_W-1:0]      rate_reg;

    logic [COUNT_WIDTH-1:0] mcand_reg;
    logic [RATE_W-1:0]      mplier_reg;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [CYC_W-1:0]       div_reg;
    logic [CYC_W-1:0]       rem_reg, rem_next;
    logic [FREQ_W-1:0]      quo_reg;
    logic                   sat_reg;
    logic                   absent_reg;

    logic                   rsp_valid_reg;
    efm_rsp_t               rsp_reg;

    logic [COUNT_WIDTH-1:0] d_edges;
    logic [CYC_W-1:0]       d_cyc;
    logic [CYC_W:0]         rem_shift, rem_diff;
    logic                   rem_ge;
    logic [FREQ_W-1:0]      inst;

    assign d_edges = edge_total_reg - last_edges_reg;
    assign d_cyc   = now_cycles - last_cycles_reg;

    // shift-add, multiplier msb first
    assign prod_next = {prod_reg[PW-2:0], 1'b0}
                     + (mplier_reg[RATE_W-1] ? PW'(mcand_reg) : PW'(0));

    // restoring divide, one dividend bit per step; remainder stays below divisor
    assign rem_shift = {rem_reg, prod_reg[PW-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign rem_next  = rem_ge ? rem_diff[CYC_W-1:0] : rem_shift[CYC_W-1:0];

    assign inst = sat_reg ? '1 : quo_reg;

    always_comb
    begin
        if (absent_reg)
            avg_next = '0;
        else if (avg_reg == '0)
            avg_next = inst;
        else
            avg_next = avg_reg - (avg_reg >> EMA_SHIFT) + (inst >> EMA_SHIFT);
    end

    assign sts.absent   = absent_reg;
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg  <= '0;
            last_edges_reg  <= '0;
            last_cycles_reg <= '0;
            avg_reg         <= '0;
            rate_reg        <= RATE_RESET;
            absent_reg      <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rate_reg <= cfg_data;
            if (cmd.edge_inc)
                edge_total_reg <= edge_total_reg + 1'b1;
            if (cmd.base_set)
            begin
                last_cycles_reg <= now_cycles;
                last_edges_reg  <= '0;
            end
            if (cmd.query_start)
            begin
                last_cycles_reg <= now_cycles;
                last_edges_reg  <= edge_total_reg;
                absent_reg      <= (d_edges == '0) || (d_cyc == '0);
            end
            if (cmd.finish)
            begin
                avg_reg       <= avg_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // operand and result registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            mcand_reg  <= d_edges;
            mplier_reg <= rate_reg;
            div_reg    <= d_cyc;
            prod_reg   <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            sat_reg    <= 1'b0;
        end
        if (cmd.mul_step)
        begin
            prod_reg   <= prod_next;
            mplier_reg <= {mplier_reg[RATE_W-2:0], 1'b0};
        end
        if (cmd.div_step)
        begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
            rem_reg  <= rem_next;
            if (cmd.div_high)
                sat_reg <= sat_reg | rem_ge;
            else
                quo_reg <= {quo_reg[FREQ_W-2:0], rem_ge};
        end
        if (cmd.finish)
        begin
            rsp_reg.freq_hz       <= avg_next;
            rsp_reg.signal_absent <= absent_reg;
        end
    end

endmodule

>>> hdl/edge_frequency_meter_ema.sv
// edge_frequency_meter_ema: top level of the edge frequency meter
// joins efm_ctrl and efm_dp; uses efm_pkg
//
// Edge and baseline beats give no result. A query beat runs a multiply phase
// and then a divide phase: a shift-add multiplier handles one bit of
// cycles_per_sec per cycle, then a restoring divider takes one bit of the
// COUNT_WIDTH+32 bit product per cycle, and a done state writes the result
// once the output register is free. A query with no new edges or no elapsed
// cycles skips the multiply and divide steps. The request side stalls while
// a query is in progress; a finished result sits in an output register, so new
// beats are taken while it waits. cycles_per_sec is written through the cfg
// channel, which is always ready, and should be written only while idle.
module edge_frequency_meter_ema import efm_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  efm_req_t          req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output efm_rsp_t          rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RATE_W-1:0] cfg_data
);

    efm_cmd_t cmd;
    efm_sts_t sts;

    assign cfg_ready = 1'b1;

    efm_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    efm_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .now_cycles (req.now_cycles),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

>>> bench/edge_frequency_meter_ema_tb.sv
// edge_frequency_meter_ema_tb: self-checking bench for the edge frequency meter
// scripted beats first, then random edge/query/baseline traffic under several rates and idle mixes
// depends on efm_pkg and edge_frequency_meter_ema
module edge_frequency_meter_ema_tb import efm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          COUNT_W         = 32;
    localparam time         CLK_PERIOD      = 10ns;
    localparam int          RESET_CYCLES    = 9;
    localparam int          SETTLE_CYCLES   = 120;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          ITEMS_PER_PHASE = 220;
    localparam int          PHASE_COUNT     = 5;
    localparam logic [1:0]  REQ_SPARE       = 2'd3;

    typedef enum logic {
        ROW_BEAT,
        ROW_RATE
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [1:0]       code;
        logic [CYC_W-1:0] value;
        logic             pinned;
        efm_rsp_t         want;
    } script_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    efm_req_t          req;
    logic              rsp_valid;
    logic              rsp_stall;
    efm_rsp_t          rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [RATE_W-1:0] cfg_data;

    // predictor state
    logic [COUNT_W-1:0] edge_count  = '0;
    logic [COUNT_W-1:0] edge_mark   = '0;
    logic [CYC_W-1:0]   cycle_mark  = '0;
    logic [FREQ_W-1:0]  smooth_hz   = '0;
    logic [RATE_W-1:0]  rate_hz     = RATE_RESET;

    efm_rsp_t           freq_expected[$];
    script_row_t        script[$];
    logic [CYC_W-1:0]   cycle_clock = '0;
    int unsigned        send_gap_pct   = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        hold_left      = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles   = 0;

    edge_frequency_meter_ema #(
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // updates the predicted meter state for one accepted beat; returns 1 when a result is due
    function automatic bit advance_meter(input efm_req_t beat, output efm_rsp_t rsp_out);
        logic [CYC_W-1:0]          span_cycles;
        logic [COUNT_W-1:0]        span_edges;
        logic [COUNT_W+RATE_W-1:0] product;
        logic [COUNT_W+RATE_W-1:0] ratio;
        logic [FREQ_W-1:0]         inst_hz;
        bit                        has_rsp;
        has_rsp = 1'b0;
        rsp_out = '0;
        case (beat.req_type)
            REQ_EDGE:
                edge_count = edge_count + 1'b1;
            REQ_BASE:
            begin
                cycle_mark = beat.now_cycles;
                edge_mark  = '0;
            end
            REQ_QUERY:
            begin
                span_cycles = beat.now_cycles - cycle_mark;
                span_edges  = edge_count - edge_mark;
                cycle_mark  = beat.now_cycles;
                edge_mark   = edge_count;
                has_rsp     = 1'b1;
                if (span_edges == '0 || span_cycles == '0)
                begin
                    smooth_hz             = '0;
                    rsp_out.signal_absent = 1'b1;
                end
                else
                begin
                    product = span_edges * rate_hz;
                    ratio   = product / span_cycles;
                    inst_hz = ((ratio >> FREQ_W) != '0) ? '1 : ratio[FREQ_W-1:0];
                    if (smooth_hz == '0)
                        smooth_hz = inst_hz;
                    else
                        smooth_hz = smooth_hz - (smooth_hz >> EMA_SHIFT) + (inst_hz >> EMA_SHIFT);
                end
                rsp_out.freq_hz = smooth_hz;
            end
            default: ; // spare code is dropped by the block
        endcase
        return has_rsp;
    endfunction

    function automatic void add_beat(input logic [1:0] code, input logic [CYC_W-1:0] now,
                                     input logic pinned = 1'b0,
                                     input logic [FREQ_W-1:0] want_hz = '0,
                                     input logic want_absent = 1'b0);
        script_row_t row;
        row.kind  = ROW_BEAT;
        row.code  = code;
        row.value = now;
        row.pinned = pinned;
        row.want  = {want_hz, want_absent};
        script.push_back(row);
    endfunction

    function automatic void add_rate(input logic [RATE_W-1:0] value);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_RATE;
        row.value = value;
        script.push_back(row);
    endfunction

    function automatic logic [CYC_W-1:0] next_gap();
        logic [CYC_W-1:0] gap;
        case ($urandom_range(0, 9))
            0:       gap = '0;
            1, 2:    gap = $urandom_range(1, 16);
            3, 4, 5: gap = $urandom_range(17, 4096);
            6, 7:    gap = $urandom_range(4097, 1 << 20);
            default: gap = $urandom();
        endcase
        return gap;
    endfunction

    // offers one request beat, holds it through stalls, predicts on acceptance
    task automatic drive_request(input logic [1:0] code, input logic [CYC_W-1:0] now,
                                 input logic pinned = 1'b0, input efm_rsp_t pinned_rsp = '0);
        efm_rsp_t model_rsp;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req       = {code, now};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (advance_meter(req, model_rsp))
            freq_expected.push_back(pinned ? pinned_rsp : model_rsp);
    endtask

    // rate is only changed once every pending result is in and the datapath has settled
    task automatic write_rate(input logic [RATE_W-1:0] value);
        @(negedge clk);
        req_valid = 1'b0;
        while (freq_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rate_hz = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly edge bursts closed by a query at a plausible counter value, plus noise
    task automatic run_traffic(input int unsigned budget);
        int unsigned sent;
        int unsigned pick;
        int unsigned burst;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                drive_request(REQ_SPARE, $urandom());
            end
            else if (pick < 12)
            begin
                cycle_clock = cycle_clock + next_gap();
                drive_request(REQ_BASE, cycle_clock);
                sent++;
            end
            else if (pick < 16)
            begin
                cycle_clock = $urandom();
                drive_request(REQ_QUERY, cycle_clock);
                sent++;
            end
            else
            begin
                burst = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
                repeat (burst) drive_request(REQ_EDGE, $urandom());
                cycle_clock = cycle_clock + next_gap();
                drive_request(REQ_QUERY, cycle_clock);
                sent += burst + 1;
            end
        end
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                rsp_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_rsp
        efm_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (freq_expected.size() == 0)
            begin
                $display("%0t: result beat with nothing pending: freq_hz=%0d signal_absent=%0b",
                         $time, rsp.freq_hz, rsp.signal_absent);
                mismatch_count++;
            end
            else
            begin
                want = freq_expected.pop_front();
                if (rsp.freq_hz !== want.freq_hz)
                begin
                    $display("%0t: freq_hz expected %0d got %0d",
                             $time, want.freq_hz, rsp.freq_hz);
                    mismatch_count++;
                end
                if (rsp.signal_absent !== want.signal_absent)
                begin
                    $display("%0t: signal_absent expected %0b got %0b",
                             $time, want.signal_absent, rsp.signal_absent);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [RATE_W-1:0] phase_rate;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;

        // reset rate in force: empty window, first seed, no new edges, zero elapsed cycles
        add_beat(REQ_QUERY, 32'd0, 1'b1, '0, 1'b1);
        add_beat(REQ_EDGE, 32'hFFFF_FFFF);
        add_beat(REQ_EDGE, 32'h0000_0000);
        add_beat(REQ_EDGE, 32'hAAAA_5555);
        add_beat(REQ_EDGE, 32'h5555_AAAA);
        add_beat(REQ_QUERY, 32'd200, 1'b1, 32'd4000000, 1'b0);
        add_beat(REQ_QUERY, 32'd200, 1'b1, '0, 1'b1);
        add_beat(REQ_EDGE, 32'd0);
        add_beat(REQ_QUERY, 32'd200, 1'b1, '0, 1'b1);
        add_beat(REQ_SPARE, 32'hFFFF_FFFF);
        // baseline just below the wrap, then a query past it
        add_beat(REQ_BASE, 32'hFFFF_FFF0);
        add_beat(REQ_QUERY, 32'h0000_0010);
        add_beat(REQ_EDGE, 32'd0);
        add_beat(REQ_QUERY, 32'h0000_0011);
        // top rate: quotient overflows and saturates
        add_rate('1);
        add_beat(REQ_EDGE, 32'd0);
        add_beat(REQ_EDGE, 32'd0);
        add_beat(REQ_QUERY, 32'h0000_0012);
        // zero rate keeps an emptied average empty
        add_rate('0);
        add_beat(REQ_QUERY, 32'h0000_0012, 1'b1, '0, 1'b1);
        add_beat(REQ_EDGE, 32'd0);
        add_beat(REQ_QUERY, 32'h0000_0100, 1'b1, '0, 1'b0);
        add_rate(32'd1);
        add_beat(REQ_EDGE, 32'd0);
        add_beat(REQ_QUERY, 32'h0000_0101);
        add_beat(REQ_EDGE, 32'd0);
        add_beat(REQ_QUERY, 32'hFFFF_FFFF);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < script.size(); i++)
        begin
            if (script[i].kind == ROW_RATE)
                write_rate(script[i].value);
            else
                drive_request(script[i].code, script[i].value, script[i].pinned, script[i].want);
        end
        cycle_clock = 32'h0000_1000;

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    phase_rate = RATE_RESET;
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    phase_rate = '1;
                    send_gap_pct = 85;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    phase_rate = 32'd1;
                    send_gap_pct = 0;
                    recv_stall_pct = 85;
                end
                3:
                begin
                    phase_rate = $urandom();
                    send_gap_pct = 17;
                    recv_stall_pct = 17;
                end
                default:
                begin
                    phase_rate = $urandom_range(1000, 50000000);
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            write_rate(phase_rate);
            // long receiver hold-off so finished queries back up into the request side
            if (p == 0)
                hold_left = HOLD_CYCLES;
            run_traffic(ITEMS_PER_PHASE);
        end

        @(negedge clk);
        req_valid = 1'b0;
        while (freq_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/efm_pkg.sv
hdl/efm_ctrl.sv
hdl/efm_dp.sv
hdl/edge_frequency_meter_ema.sv
bench/edge_frequency_meter_ema_tb.sv
